/* hw/rtl/clu_pkg.sv */
// ----------------------------------------------------------------------------
// clu_pkg: shared types and constants
// States, status codes, saturation helper and handshakes between the Crout
// core and its arithmetic units.
// ----------------------------------------------------------------------------
package clu_pkg;

    localparam int DEF_MAX_SIZE = 8;
    localparam int SIZE_W       = 4;
    localparam int DATA_W       = 32;
    localparam int ROUND_W      = 48;   // rounded Q16.16 product
    localparam int ACC_W        = 53;   // dot sum and difference headroom
    localparam int DIV_STEPS    = 48;   // quotient bits of (num << 16) / den
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_PIVOT = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_ACC,
        S_FIN,
        S_DIV,
        S_DET_RD,
        S_DET_MUL,
        S_DET_ACC,
        S_ORD,
        S_OVAL
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic                     flag;
        logic signed [DATA_W-1:0] value;
    } sat_res_t;

    function automatic sat_res_t sat32(input logic signed [ACC_W-1:0] v);
        sat_res_t r;
        if (v > ACC_W'(64'sh7FFF_FFFF)) begin
            r.flag  = 1'b1;
            r.value = 32'sh7FFF_FFFF;
        end
        else if (v < -ACC_W'(64'sh8000_0000)) begin
            r.flag  = 1'b1;
            r.value = 32'sh8000_0000;
        end
        else begin
            r.flag  = 1'b0;
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/clu_mul.sv */
// ----------------------------------------------------------------------------
// clu_mul: shared Q16.16 multiplier
// Registered 32x32 signed product, rounded to nearest with ties up.
// ----------------------------------------------------------------------------
module clu_mul
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [clu_pkg::DATA_W-1:0]     a,
    input  logic signed [clu_pkg::DATA_W-1:0]     b,
    output logic signed [clu_pkg::ROUND_W-1:0]    rounded
);

    logic signed [2*clu_pkg::DATA_W-1:0] prod_reg;
    logic signed [2*clu_pkg::DATA_W-1:0] biased;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    // floor((p + 0.5 LSB) / 2^16)
    assign biased  = prod_reg + 64'sd32768;
    assign rounded = biased[2*clu_pkg::DATA_W-1:16];

endmodule

/* hw/rtl/clu_div.sv */
// ----------------------------------------------------------------------------
// clu_div: Q16.16 divider
// Restoring divide of (num << 16) by den, one quotient bit per cycle,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module clu_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  clu_pkg::div_ctrl_t                 ctrl,
    input  logic signed [clu_pkg::DATA_W-1:0]  num,
    input  logic signed [clu_pkg::DATA_W-1:0]  den,
    output clu_pkg::div_stat_t                 stat,
    output logic signed [clu_pkg::DATA_W-1:0]  quot,
    output logic                               sat
);

    localparam int QW = clu_pkg::DIV_STEPS;
    localparam int DW = clu_pkg::DATA_W;

    logic                           busy_reg, busy_next;
    logic                           fin_reg, fin_next;
    logic                           done_reg, done_next;
    logic [clu_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]                  rem_reg, rem_next;
    logic [QW-1:0]                  quo_reg, quo_next;
    logic [DW-1:0]                  den_reg, den_next;
    logic                           neg_reg, neg_next;
    logic signed [DW-1:0]           quot_reg, quot_next;
    logic                           sat_reg, sat_next;
    logic [DW-1:0]                  num_mag, den_mag;
    logic [DW:0]                    trial;
    logic                           big_pos, big_neg;

    assign num_mag = num[DW-1] ? DW'(-num) : DW'(num);
    assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);
    assign trial   = {rem_reg, quo_reg[QW-1]};
    assign big_pos = |quo_reg[QW-1:DW-1];
    assign big_neg = (|quo_reg[QW-1:DW]) || (quo_reg[DW-1] && (|quo_reg[DW-2:0]));

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        sat_next  = sat_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = {num_mag, 16'h0000};
            den_next  = den_mag;
            neg_next  = num[DW-1] ^ den[DW-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == clu_pkg::DIV_CNT_W'(QW - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
            if (!neg_reg)
            begin
                sat_next  = big_pos;
                quot_next = big_pos ? 32'sh7FFF_FFFF : $signed(quo_reg[DW-1:0]);
            end
            else
            begin
                sat_next  = big_neg;
                quot_next = big_neg ? 32'sh8000_0000 : $signed(DW'(-quo_reg[DW-1:0]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
        sat_reg  <= sat_next;
    end

    assign stat.busy = busy_reg | fin_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;
    assign sat       = sat_reg;

endmodule

/* hw/rtl/crout_lu_determinant_core.sv */
// ----------------------------------------------------------------------------
// crout_lu_determinant_core: Crout LU factorization and determinant
// Loads an n x n Q16.16 matrix, factors it in place and streams L, U and det.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg_wr_en/cfg_wr_data set n (0 acts as 1, above MAX_SIZE as MAX_SIZE)
//    and restart the load. Write only while idle.
//  - s_axis: one element word per cycle, row-major, while s_axis_tready.
//  - After the last element tready drops. The sequencer walks the Crout
//    loops over one shared multiplier (read, multiply, accumulate per dot
//    term) and one bit-serial divider (per U entry: read, start, 48 steps,
//    sign fix, write) on a 2-read/1-write store.
//  - m_axis: n*n result words, row-major; tlast marks the
//    word holding the determinant and tuser the status (0 ok, 1 zero
//    pivot, 2 saturation). Zero pivot zeroes all L and U values.
//  - A stalled receiver holds the result word; nothing else moves.
//  - Reset: n = 8, ready to load. The store is not cleared.
// ----------------------------------------------------------------------------
module crout_lu_determinant_core #(
    parameter int MAX_SIZE = clu_pkg::DEF_MAX_SIZE
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [3:0]    cfg_wr_data,     // matrix_size
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,    // element_value
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // row_index[2:0] column_index[5:3] lower_value[37:6]
    // upper_value[69:38] determinant[101:70] zero pad[103:102]
    output logic [103:0]  m_axis_tdata,
    output logic          m_axis_tlast,    // last
    output logic [1:0]    m_axis_tuser     // status
);

    localparam int CNT_W  = $clog2(MAX_SIZE + 1);
    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DW     = clu_pkg::DATA_W;
    localparam int AW     = clu_pkg::ACC_W;

    clu_pkg::state_t state_reg, state_next;

    logic [clu_pkg::SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]           n_eff;
    logic [CNT_W-1:0]           row_reg, row_next, col_reg, col_next;
    logic [CNT_W-1:0]           k_reg, k_next, m_reg, m_next;
    logic                       phu_reg, phu_next;       // U phase
    logic signed [AW-1:0]       acc_reg, acc_next;
    logic signed [DW-1:0]       piv_reg, piv_next;
    logic signed [DW-1:0]       det_reg, det_next;
    logic                       sat_reg, sat_next;
    logic                       fail_reg, fail_next;

    logic signed [DW-1:0]       mem [DEPTH];
    logic signed [DW-1:0]       rd_a, rd_b;
    logic [ADDR_W-1:0]          addr_rc, addr_a, addr_b;
    logic                       we;
    logic signed [DW-1:0]       wdata;

    logic                       in_acc, out_acc;
    logic                       row_end, col_end, k_end, is_last;
    logic                       dot_more, zero_piv;
    clu_pkg::sat_res_t          diff_sat, det_sat;

    logic                       mul_en;
    logic signed [DW-1:0]       mul_a, mul_b;
    logic signed [clu_pkg::ROUND_W-1:0] mul_r;

    clu_pkg::div_ctrl_t         div_ctrl;
    clu_pkg::div_stat_t         div_stat;
    logic signed [DW-1:0]       div_quot;
    logic                       div_sat;

    logic signed [DW-1:0]       lower_v, upper_v, det_v;
    logic [1:0]                 stat_v;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] r,
                                                   input logic [CNT_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_SIZE + int'(c));
    endfunction

    // effective size clamp
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(size_reg) > MAX_SIZE)
        begin
            n_eff = CNT_W'(MAX_SIZE);
        end
        else
        begin
            n_eff = CNT_W'(size_reg);
        end
    end

    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign out_acc  = m_axis_tvalid & m_axis_tready;
    assign row_end  = (row_reg + 1'b1) == n_eff;
    assign col_end  = (col_reg + 1'b1) == n_eff;
    assign k_end    = (k_reg + 1'b1) == n_eff;
    assign is_last  = row_end & col_end;
    assign dot_more = m_reg < k_reg;

    assign addr_rc  = addr_of(row_reg, col_reg);
    assign addr_a   = (state_reg == clu_pkg::S_DOT_RD && dot_more) ?
                      addr_of(row_reg, m_reg) : addr_rc;
    assign addr_b   = addr_of(m_reg, col_reg);

    // A - sum, saturated
    assign diff_sat = clu_pkg::sat32(AW'(rd_a) - acc_reg);
    assign det_sat  = clu_pkg::sat32(AW'(mul_r));
    assign zero_piv = !phu_reg && (row_reg == k_reg) && (diff_sat.value == '0);

    // factor store: 2 registered reads, 1 write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr_rc] <= wdata;
        end
        rd_a <= mem[addr_a];
        rd_b <= mem[addr_b];
    end

    clu_mul u_mul
    (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .rounded (mul_r)
    );

    clu_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (diff_sat.value),
        .den   (piv_reg),
        .stat  (div_stat),
        .quot  (div_quot),
        .sat   (div_sat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clu_pkg::S_LOAD:
            begin
                if (in_acc && is_last)
                begin
                    state_next = clu_pkg::S_INIT;
                end
            end
            clu_pkg::S_INIT:    state_next = clu_pkg::S_DOT_RD;
            clu_pkg::S_DOT_RD:  state_next = dot_more ? clu_pkg::S_DOT_MUL : clu_pkg::S_FIN;
            clu_pkg::S_DOT_MUL: state_next = clu_pkg::S_DOT_ACC;
            clu_pkg::S_DOT_ACC: state_next = clu_pkg::S_DOT_RD;
            clu_pkg::S_FIN:
            begin
                if (phu_reg)
                begin
                    state_next = clu_pkg::S_DIV;
                end
                else if (zero_piv)
                begin
                    state_next = clu_pkg::S_ORD;
                end
                else if (!row_end || !k_end)
                begin
                    state_next = clu_pkg::S_DOT_RD;
                end
                else
                begin
                    state_next = clu_pkg::S_DET_RD;
                end
            end
            clu_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = clu_pkg::S_DOT_RD;
                end
            end
            clu_pkg::S_DET_RD:  state_next = clu_pkg::S_DET_MUL;
            clu_pkg::S_DET_MUL: state_next = clu_pkg::S_DET_ACC;
            clu_pkg::S_DET_ACC: state_next = row_end ? clu_pkg::S_ORD : clu_pkg::S_DET_RD;
            clu_pkg::S_ORD:     state_next = clu_pkg::S_OVAL;
            clu_pkg::S_OVAL:
            begin
                if (out_acc)
                begin
                    state_next = is_last ? clu_pkg::S_LOAD : clu_pkg::S_ORD;
                end
            end
            default:            state_next = clu_pkg::S_LOAD;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready  = 1'b0;
        m_axis_tvalid  = 1'b0;
        we             = 1'b0;
        wdata          = diff_sat.value;
        mul_en         = 1'b0;
        mul_a          = rd_a;
        mul_b          = rd_b;
        div_ctrl.start = 1'b0;
        unique case (state_reg)
            clu_pkg::S_LOAD:
            begin
                s_axis_tready = 1'b1;
                we            = in_acc;
                wdata         = $signed(s_axis_tdata);
            end
            clu_pkg::S_DOT_MUL:
            begin
                mul_en = 1'b1;
            end
            clu_pkg::S_FIN:
            begin
                we             = !phu_reg;
                div_ctrl.start = phu_reg;
            end
            clu_pkg::S_DIV:
            begin
                we    = div_stat.done;
                wdata = div_quot;
            end
            clu_pkg::S_DET_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = det_reg;
                mul_b  = rd_a;
            end
            clu_pkg::S_OVAL:
            begin
                m_axis_tvalid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // loop counters and datapath registers
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        k_next    = k_reg;
        m_next    = m_reg;
        phu_next  = phu_reg;
        acc_next  = acc_reg;
        piv_next  = piv_reg;
        det_next  = det_reg;
        sat_next  = sat_reg;
        fail_next = fail_reg;
        case (state_reg)
            clu_pkg::S_LOAD:
            begin
                if (in_acc)
                begin
                    col_next = col_end ? '0 : col_reg + 1'b1;
                    if (col_end)
                    begin
                        row_next = row_end ? '0 : row_reg + 1'b1;
                    end
                end
            end
            clu_pkg::S_INIT:
            begin
                row_next  = '0;
                col_next  = '0;
                k_next    = '0;
                m_next    = '0;
                phu_next  = 1'b0;
                acc_next  = '0;
                sat_next  = 1'b0;
                fail_next = 1'b0;
            end
            clu_pkg::S_DOT_ACC:
            begin
                acc_next = acc_reg + AW'(mul_r);
                m_next   = m_reg + 1'b1;
            end
            clu_pkg::S_FIN:
            begin
                sat_next = sat_reg | diff_sat.flag;
                acc_next = '0;
                m_next   = '0;
                if (!phu_reg)
                begin
                    if (row_reg == k_reg)
                    begin
                        piv_next = diff_sat.value;
                    end
                    if (zero_piv)
                    begin
                        fail_next = 1'b1;
                        row_next  = '0;
                        col_next  = '0;
                    end
                    else if (!row_end)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                    else if (!k_end)
                    begin
                        // U row k, columns k+1 ..
                        phu_next = 1'b1;
                        row_next = k_reg;
                        col_next = k_reg + 1'b1;
                    end
                    else
                    begin
                        row_next = '0;
                        col_next = '0;
                        det_next = clu_pkg::Q_ONE;
                    end
                end
            end
            clu_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    sat_next = sat_reg | div_sat;
                    if (!col_end)
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    else
                    begin
                        phu_next = 1'b0;
                        k_next   = k_reg + 1'b1;
                        row_next = k_reg + 1'b1;
                        col_next = k_reg + 1'b1;
                    end
                end
            end
            clu_pkg::S_DET_ACC:
            begin
                det_next = det_sat.value;
                sat_next = sat_reg | det_sat.flag;
                if (row_end)
                begin
                    row_next = '0;
                    col_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    col_next = col_reg + 1'b1;
                end
            end
            clu_pkg::S_OVAL:
            begin
                if (out_acc)
                begin
                    col_next = col_end ? '0 : col_reg + 1'b1;
                    if (col_end)
                    begin
                        row_next = row_end ? '0 : row_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (cfg_wr_en)
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clu_pkg::S_LOAD;
            size_reg  <= clu_pkg::SIZE_RESET;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
            m_reg     <= '0;
            phu_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            fail_reg  <= 1'b0;
            det_reg   <= clu_pkg::Q_ONE;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
            phu_reg   <= phu_next;
            sat_reg   <= sat_next;
            fail_reg  <= fail_next;
            det_reg   <= det_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        piv_reg <= piv_next;
    end

    // result word: L holds diagonal and below, U strictly above with unit diagonal
    always_comb
    begin
        lower_v = '0;
        upper_v = '0;
        if (!fail_reg)
        begin
            if (row_reg >= col_reg)
            begin
                lower_v = rd_a;
            end
            if (row_reg == col_reg)
            begin
                upper_v = clu_pkg::Q_ONE;
            end
            else if (col_reg > row_reg)
            begin
                upper_v = rd_a;
            end
        end
        det_v  = '0;
        stat_v = clu_pkg::STAT_OK;
        if (is_last)
        begin
            if (fail_reg)
            begin
                stat_v = clu_pkg::STAT_PIVOT;
            end
            else
            begin
                det_v  = det_reg;
                stat_v = sat_reg ? clu_pkg::STAT_SAT : clu_pkg::STAT_OK;
            end
        end
    end

    assign m_axis_tdata = {2'b00, det_v, upper_v, lower_v, 3'(col_reg), 3'(row_reg)};
    assign m_axis_tlast = is_last;
    assign m_axis_tuser = stat_v;

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("load and output active together");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == clu_pkg::STAT_OK))
        else $error("status on non-final word");

    a_pivot_det: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == clu_pkg::STAT_PIVOT)
            |-> (m_axis_tdata[101:70] == '0 && m_axis_tdata[69:6] == '0))
        else $error("zero pivot word carries data");

    a_div_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == clu_pkg::S_DIV && we) |-> $past(div_stat.busy))
        else $error("quotient written without a divide");

endmodule
